// ----- rtl/auip_pkg.sv -----
// auip_pkg: character codes, digit decode, status codes and shared types
// for the ASCII unsigned integer parser. No dependencies.
package auip_pkg;

    typedef logic [7:0] char_t;
    typedef logic [5:0] digit_t;
    typedef logic [1:0] status_t;

    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_BAD_BASE  = 2'd1;
    localparam status_t STATUS_RANGE     = 2'd2;

    localparam char_t CHAR_ZERO    = 8'd48;
    localparam char_t CHAR_NINE    = 8'd57;
    localparam char_t CHAR_UPPER_A = 8'd65;
    localparam char_t CHAR_UPPER_Z = 8'd90;
    localparam char_t CHAR_LOWER_A = 8'd97;
    localparam char_t CHAR_LOWER_Z = 8'd122;
    localparam char_t CHAR_SPACE   = 8'd32;
    localparam char_t CHAR_TAB     = 8'd9;
    localparam char_t CHAR_CR      = 8'd13;
    localparam char_t CHAR_PLUS    = 8'd43;

    localparam digit_t RADIX_MAX     = 6'd36;
    localparam digit_t RADIX_DEFAULT = 6'd10;
    localparam digit_t NO_DIGIT      = 6'd36;
    localparam digit_t LETTER_BASE   = 6'd10;

    // Case-insensitive digit value; NO_DIGIT for anything else.
    function automatic digit_t digit_value(input char_t c);
        char_t u;
        begin
            u = c;
            if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
            begin
                u = c - CHAR_SPACE;
            end
            if (u >= CHAR_ZERO && u <= CHAR_NINE)
            begin
                digit_value = digit_t'(u - CHAR_ZERO);
            end
            else if (u >= CHAR_UPPER_A && u <= CHAR_UPPER_Z)
            begin
                digit_value = digit_t'(u - CHAR_UPPER_A) + LETTER_BASE;
            end
            else
            begin
                digit_value = NO_DIGIT;
            end
        end
    endfunction

    function automatic logic is_space(input char_t c);
        is_space = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

endpackage

// ----- rtl/auip_char_if.sv -----
// auip_char_if: valid/ready channel carrying one string character.
// Depends on auip_pkg.
interface auip_char_if;
    logic              valid;
    logic              ready;
    auip_pkg::char_t   char_code;
    logic              string_start;

    modport source (output valid, output char_code, output string_start, input ready);
    modport sink   (input valid, input char_code, input string_start, output ready);
endinterface

// ----- rtl/auip_result_if.sv -----
// auip_result_if: valid/ready channel carrying one parse result.
// Depends on auip_pkg.
interface auip_result_if #(
    parameter int VALUE_BITS  = 64,
    parameter int OFFSET_BITS = 16
);
    logic                    valid;
    logic                    ready;
    logic [VALUE_BITS-1:0]   parsed_value;
    logic [OFFSET_BITS-1:0]  end_offset;
    auip_pkg::status_t       status;

    modport source (output valid, output parsed_value, output end_offset, output status,
                    input ready);
    modport sink   (input valid, input parsed_value, input end_offset, input status,
                    output ready);
endinterface

// ----- rtl/ascii_unsigned_integer_parser.sv -----
// ascii_unsigned_integer_parser: streaming ASCII to unsigned integer converter.
// Depends on auip_pkg, auip_char_if, auip_result_if.
//
//  channel   | dir | handshake    | payload
//  ----------+-----+--------------+---------------------------------------
//  chars     | in  | valid/ready  | char_code, string_start
//  result    | out | valid/ready  | parsed_value, end_offset, status
//  cfg       | in  | cfg_wr_en    | cfg_wr_data (number_base)
//
// One character per cycle unless a stalled result holds it: a request lands in the
// input register, and as it leaves, one multiply-add (accumulator * radix + digit)
// with overflow check updates the parse state and, at a string end, loads the
// result register; result valid rises as the ending character leaves the input register.
// A stalled result holds the input register; chars.ready drops only then.
// rst_n asynchronously clears control state; base resets to ten.
module ascii_unsigned_integer_parser #(
    parameter int VALUE_BITS  = 64,
    parameter int OFFSET_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  auip_pkg::char_t          cfg_wr_data,
    auip_char_if.sink                chars,
    auip_result_if.source            result
);
    import auip_pkg::*;

    localparam int RADIX_BITS = $bits(digit_t);
    localparam int PROD_BITS  = VALUE_BITS + RADIX_BITS;

    localparam logic [1:0] PH_DONE = 2'd0;
    localparam logic [1:0] PH_LEAD = 2'd1;
    localparam logic [1:0] PH_SIGN = 2'd2;
    localparam logic [1:0] PH_DIGS = 2'd3;

    localparam logic [VALUE_BITS-1:0]  VALUE_MAX  = {VALUE_BITS{1'b1}};
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

    char_t                    base_reg;

    logic                     s_valid_reg;
    char_t                    s_char_reg;
    logic                     s_start_reg;

    logic [1:0]               phase_reg, phase_next;
    logic [VALUE_BITS-1:0]    acc_reg, acc_next;
    logic [OFFSET_BITS-1:0]   pos_reg, pos_next;
    digit_t                   radix_reg, radix_next;

    logic                     out_valid_reg;
    logic [VALUE_BITS-1:0]    out_value_reg;
    logic [OFFSET_BITS-1:0]   out_offset_reg;
    status_t                  out_status_reg;

    logic                     fire;
    logic                     emit;
    logic [VALUE_BITS-1:0]    e_value;
    logic [OFFSET_BITS-1:0]   e_offset;
    status_t                  e_status;

    logic                     base_bad;
    logic [1:0]               eff_phase;
    logic [VALUE_BITS-1:0]    eff_acc;
    logic [OFFSET_BITS-1:0]   eff_pos;
    logic [OFFSET_BITS-1:0]   pos_bump;
    digit_t                   digit;
    logic [PROD_BITS-1:0]     wide;
    logic                     overflow;

    assign fire        = s_valid_reg && (!out_valid_reg || result.ready);
    assign chars.ready = !s_valid_reg || fire;

    assign result.valid        = out_valid_reg;
    assign result.parsed_value = out_value_reg;
    assign result.end_offset   = out_offset_reg;
    assign result.status       = out_status_reg;

    assign base_bad  = (base_reg == 8'd1) || (base_reg > char_t'(RADIX_MAX));
    assign eff_phase = s_start_reg ? PH_LEAD : phase_reg;
    assign eff_acc   = s_start_reg ? '0 : acc_reg;
    assign eff_pos   = s_start_reg ? '0 : pos_reg;
    assign pos_bump  = (eff_pos == OFFSET_MAX) ? eff_pos : eff_pos + 1'b1;
    assign digit     = digit_value(s_char_reg);

    always_comb
    begin
        radix_next = radix_reg;
        if (s_start_reg)
        begin
            radix_next = (base_reg == 8'd0) ? RADIX_DEFAULT : base_reg[RADIX_BITS-1:0];
        end
    end

    // acc * radix + digit > VALUE_MAX exactly when the upper bits are set
    assign wide     = PROD_BITS'(eff_acc) * PROD_BITS'(radix_next) + PROD_BITS'(digit);
    assign overflow = |wide[PROD_BITS-1:VALUE_BITS];

    always_comb
    begin
        emit       = 1'b0;
        e_value    = '0;
        e_offset   = '0;
        e_status   = STATUS_OK;
        phase_next = eff_phase;
        acc_next   = eff_acc;
        pos_next   = eff_pos;

        if (s_start_reg && base_bad)
        begin
            emit       = 1'b1;
            e_status   = STATUS_BAD_BASE;
            phase_next = PH_DONE;
        end
        else if (eff_phase == PH_DONE)
        begin
            phase_next = PH_DONE;
        end
        else if (eff_phase == PH_LEAD && is_space(s_char_reg))
        begin
            pos_next = pos_bump;
        end
        else if (eff_phase == PH_LEAD && s_char_reg == CHAR_PLUS)
        begin
            pos_next   = pos_bump;
            phase_next = PH_SIGN;
        end
        else if (digit >= radix_next)
        begin
            emit       = 1'b1;
            phase_next = PH_DONE;
            if (eff_phase == PH_DIGS)
            begin
                e_value  = eff_acc;
                e_offset = eff_pos;
            end
        end
        else if (overflow)
        begin
            emit       = 1'b1;
            e_value    = VALUE_MAX;
            e_offset   = eff_pos;
            e_status   = STATUS_RANGE;
            phase_next = PH_DONE;
        end
        else
        begin
            acc_next   = wide[VALUE_BITS-1:0];
            pos_next   = pos_bump;
            phase_next = PH_DIGS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= char_t'(RADIX_DEFAULT);
        end
        else if (cfg_wr_en)
        begin
            base_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else if (chars.ready)
        begin
            s_valid_reg <= chars.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            s_char_reg  <= chars.char_code;
            s_start_reg <= chars.string_start;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DONE;
            acc_reg   <= '0;
            pos_reg   <= '0;
            radix_reg <= RADIX_DEFAULT;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            pos_reg   <= pos_next;
            radix_reg <= radix_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            out_value_reg  <= e_value;
            out_offset_reg <= e_offset;
            out_status_reg <= e_status;
        end
    end

    // A result always closes the string.
    a_emit_closes: assert property (@(posedge clk) disable iff (!rst_n)
        fire && emit |=> phase_reg == PH_DONE)
        else $error("parse phase not done after result");

    // A request waiting behind a stalled result is kept.
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s_valid_reg && !fire |=> s_valid_reg && $stable(s_char_reg) && $stable(s_start_reg))
        else $error("input register lost a pending request");

    a_bad_base_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg == STATUS_BAD_BASE |->
            out_value_reg == '0 && out_offset_reg == '0)
        else $error("invalid base result not zero");

    a_range_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg == STATUS_RANGE |-> out_value_reg == VALUE_MAX)
        else $error("range error result not saturated");

endmodule
